### hw/rtl/great_circle_distance_macros.svh
// assertion helpers for the distance block
`ifndef GREAT_CIRCLE_DISTANCE_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_MACROS_SVH
`ifndef SYNTH
`define GCD_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GCD_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define GCD_ASSERT_IMPL(label, clk, rst, prop, msg)
`define GCD_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

### hw/rtl/gcd_pkg.sv
`timescale 1ns / 1ps
package gcd_pkg;
  localparam int AngW = 34;
  localparam logic signed [AngW-1:0] GainQ30 = 34'sh026DD3B6A;
  localparam logic signed [AngW-1:0] OneQ30 = 34'sh040000000;
  localparam logic [63:0] OutMax = 64'd26353589000;
  localparam logic [34:0] MmScale = 35'd13176794633;

  function automatic logic signed [AngW-1:0] atan_entry(input int i);
    logic [31:0] t;
    t = 32'd0;
    case (i)
      0: t = 32'h20000000; 1: t = 32'h12E4051E; 2: t = 32'h09FB385B;
      3: t = 32'h051111D4; 4: t = 32'h028B0D43; 5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E; 7: t = 32'h00517C55; 8: t = 32'h0028BE53;
      9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
      27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
      30: t = 32'h00000001;
      default: t = 32'd0;
    endcase
    return AngW'($signed({2'b00, t}));
  endfunction

  // rounded q4.30 product
  function automatic logic signed [AngW-1:0] qmul(input logic signed [AngW-1:0] a,
                                                  input logic signed [AngW-1:0] b);
    logic signed [2*AngW-1:0] p;
    p = a * b + (68'sd1 <<< 29);
    return AngW'(p >>> 30);
  endfunction
endpackage

### hw/rtl/gcd_rot_cell.sv
`timescale 1ns / 1ps
// one rotation step for four angles at once
module gcd_rot_cell #(
  parameter int Step = 0
) (
  input  logic clk,
  input  logic signed [gcd_pkg::AngW-1:0] x_in [4],
  input  logic signed [gcd_pkg::AngW-1:0] y_in [4],
  input  logic signed [gcd_pkg::AngW-1:0] z_in [4],
  output logic signed [gcd_pkg::AngW-1:0] x_out [4],
  output logic signed [gcd_pkg::AngW-1:0] y_out [4],
  output logic signed [gcd_pkg::AngW-1:0] z_out [4]
);
  localparam int Sh = (Step > 33) ? 33 : Step;
  localparam logic signed [gcd_pkg::AngW-1:0] T = gcd_pkg::atan_entry(Step);
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (!z_in[k][gcd_pkg::AngW-1]) begin
        x_out[k] <= x_in[k] - (y_in[k] >>> Sh);
        y_out[k] <= y_in[k] + (x_in[k] >>> Sh);
        z_out[k] <= z_in[k] - T;
      end else begin
        x_out[k] <= x_in[k] + (y_in[k] >>> Sh);
        y_out[k] <= y_in[k] - (x_in[k] >>> Sh);
        z_out[k] <= z_in[k] + T;
      end
    end
  end
endmodule

### hw/rtl/gcd_vec_cell.sv
`timescale 1ns / 1ps
// one vectoring step
module gcd_vec_cell #(
  parameter int Step = 0
) (
  input  logic clk,
  input  logic signed [gcd_pkg::AngW-1:0] x_in,
  input  logic signed [gcd_pkg::AngW-1:0] y_in,
  input  logic signed [gcd_pkg::AngW-1:0] z_in,
  output logic signed [gcd_pkg::AngW-1:0] x_out,
  output logic signed [gcd_pkg::AngW-1:0] y_out,
  output logic signed [gcd_pkg::AngW-1:0] z_out
);
  localparam int Sh = (Step > 33) ? 33 : Step;
  localparam logic signed [gcd_pkg::AngW-1:0] T = gcd_pkg::atan_entry(Step);
  always_ff @(posedge clk) begin
    if (!y_in[gcd_pkg::AngW-1]) begin
      x_out <= x_in + (y_in >>> Sh);
      y_out <= y_in - (x_in >>> Sh);
      z_out <= z_in + T;
    end else begin
      x_out <= x_in - (y_in >>> Sh);
      y_out <= y_in + (x_in >>> Sh);
      z_out <= z_in - T;
    end
  end
endmodule

### hw/rtl/gcd_sqrt_cell.sv
`timescale 1ns / 1ps
// one result bit of two 62-bit square roots, restoring form
module gcd_sqrt_cell #(
  parameter int Bit = 30
) (
  input  logic        clk,
  input  logic [61:0] rem_in [2],
  input  logic [31:0] root_in [2],
  output logic [61:0] rem_out [2],
  output logic [31:0] root_out [2]
);
  logic [63:0] trial [2];
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      trial[k] = ({32'd0, root_in[k]} << (Bit + 1)) | (64'd1 << (2 * Bit));
    end
  end
  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      if ({2'b00, rem_in[k]} >= trial[k]) begin
        rem_out[k] <= 62'({2'b00, rem_in[k]} - trial[k]);
        root_out[k] <= root_in[k] | (32'd1 << Bit);
      end else begin
        rem_out[k] <= rem_in[k];
        root_out[k] <= root_in[k];
      end
    end
  end
endmodule

### hw/rtl/great_circle_distance.sv
`timescale 1ns / 1ps
// haversine great-circle distance. one coordinate pair is taken every cycle
// (busy stays low). the data path is 2*CORDIC_STEPS+45 register stages deep, and
// the distance leaves it on distance_mm together with done high. the depth
// is set by the two chains of cordic
// cells, the 31-cell square-root chain and fourteen further stages: input
// differences, modulo reduction, a three-stage reciprocal divide to binary
// angles, quadrant fold, three haversine product stages, the square-root load
// and four scaling stages. the receiver cannot stall, so each result is there
// for one cycle only. the radius register must be written while no transfer is
// in flight.
`include "great_circle_distance_macros.svh"
module great_circle_distance #(
  parameter int CORDIC_STEPS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [37:0] first_lat,
  input  logic signed [38:0] first_lon,
  input  logic signed [37:0] second_lat,
  input  logic signed [38:0] second_lon,
  output logic               done,
  output logic [34:0]        distance_mm,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam int W = gcd_pkg::AngW;
  localparam int Lat = 2 * CORDIC_STEPS + 45;

  // configuration
  logic [22:0] radius;
  assign pready = 1'b1;
  assign busy = 1'b0;
  assign prdata = (paddr == 2'd0) ? {9'd0, radius} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 23'd6371000;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      radius <= pwdata[22:0];
    end
  end

  // valid chain
  logic [Lat-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[Lat-2:0], start};
  end
  assign done = vld[Lat-1];

  // stage a: differences, then modulo reduction (period reduce by compare)
  logic signed [39:0] dla, dlo;
  logic signed [37:0] la1_a, la2_a;
  always_ff @(posedge clk) begin
    dla <= 40'(second_lat) - 40'(first_lat);
    dlo <= 40'(second_lon) - 40'(first_lon);
    la1_a <= first_lat;
    la2_a <= second_lat;
  end

  // reduce value to [0, period); the port widths keep it within one period
  function automatic logic [39:0] reduce(input logic signed [40:0] v,
                                         input logic [39:0] period);
    logic signed [42:0] m;
    logic signed [42:0] p;
    p = 43'($signed({3'b0, period}));
    m = 43'(v);
    if (m < 0) m = m + p;
    else if (m >= p) m = m - p;
    return m[39:0];
  endfunction

  logic [39:0] m_la1, m_la2, m_dla, m_dlo;
  always_ff @(posedge clk) begin
    m_la1 <= reduce(41'(la1_a), 40'd360000000000);
    m_la2 <= reduce(41'(la2_a), 40'd360000000000);
    m_dla <= reduce(41'(dla), 40'd720000000000);
    m_dlo <= reduce(41'(dlo), 40'd720000000000);
  end

  // binary angle: (m<<sh + c)/87890625 via reciprocal multiply, corrected
  // estimate from the top 32 numerator bits is low by at most three
  localparam logic [31:0] Recip = 32'd3279421168; // floor(2^58/87890625)
  localparam logic [59:0] Dvs = 60'd87890625;
  localparam logic [59:0] Dvs2 = 60'd175781250;
  localparam logic [59:0] Dvs3 = 60'd263671875;
  logic [59:0] num [4];
  logic [31:0] qest [4];
  logic [59:0] num_r [4];
  logic [63:0] qprod [4];
  logic [32:0] qlo [4];
  logic [59:0] rem [4];
  always_comb begin
    num[0] = ({20'd0, m_la1} << 20) + 60'd43945312;
    num[1] = ({20'd0, m_la2} << 20) + 60'd43945312;
    num[2] = ({20'd0, m_dla} << 19) + 60'd43945312;
    num[3] = ({20'd0, m_dlo} << 19) + 60'd43945312;
  end
  logic [31:0] bam [4];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      num_r[k] <= num[k];
      qprod[k] <= 64'(num[k][58:27]) * 64'(Recip);
    end
  end
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      qlo[k] <= qprod[k][63:31];
      rem[k] <= num_r[k] - 60'(qprod[k][63:31]) * Dvs;
    end
  end
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      bam[k] <= 32'(qlo[k] + 33'(rem[k] >= Dvs) + 33'(rem[k] >= Dvs2)
                    + 33'(rem[k] >= Dvs3));
    end
  end
  assign qest = bam;

  // rotation chain
  logic signed [W-1:0] rx [CORDIC_STEPS+1][4];
  logic signed [W-1:0] ry [CORDIC_STEPS+1][4];
  logic signed [W-1:0] rz [CORDIC_STEPS+1][4];
  logic [1:0] quad [CORDIC_STEPS+1][4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rx[0][k] = gcd_pkg::GainQ30;
      ry[0][k] = '0;
      rz[0][k] = W'({2'b00, qest[k][29:0]});
      quad[0][k] = qest[k][31:30];
    end
  end
  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_rot
    gcd_rot_cell #(.Step(s)) u_cell (
      .clk(clk), .x_in(rx[s]), .y_in(ry[s]), .z_in(rz[s]),
      .x_out(rx[s+1]), .y_out(ry[s+1]), .z_out(rz[s+1])
    );
    always_ff @(posedge clk) quad[s+1] <= quad[s];
  end

  logic signed [W-1:0] cs [4], sn [4];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      unique case (quad[CORDIC_STEPS][k])
        2'd0: begin cs[k] <= rx[CORDIC_STEPS][k]; sn[k] <= ry[CORDIC_STEPS][k]; end
        2'd1: begin cs[k] <= -ry[CORDIC_STEPS][k]; sn[k] <= rx[CORDIC_STEPS][k]; end
        2'd2: begin cs[k] <= -rx[CORDIC_STEPS][k]; sn[k] <= -ry[CORDIC_STEPS][k]; end
        default: begin cs[k] <= ry[CORDIC_STEPS][k]; sn[k] <= -rx[CORDIC_STEPS][k]; end
      endcase
    end
  end

  // haversine term, built from registered products
  logic signed [W-1:0] p_shl, p_cc, p_sho, p_shl2, p_t;
  logic signed [W:0] a_sum;
  logic [30:0] a_cl;
  always_ff @(posedge clk) begin
    p_shl <= gcd_pkg::qmul(sn[2], sn[2]);
    p_cc <= gcd_pkg::qmul(cs[0], cs[1]);
    p_sho <= gcd_pkg::qmul(sn[3], sn[3]);
    p_shl2 <= p_shl;
    p_t <= gcd_pkg::qmul(p_cc, p_sho);
    a_sum <= (W+1)'(p_shl2) + (W+1)'(p_t);
  end
  always_comb begin
    if (a_sum < 0) a_cl = '0;
    else if (a_sum > (W+1)'(gcd_pkg::OneQ30)) a_cl = 31'h40000000;
    else a_cl = a_sum[30:0];
  end

  // square roots of a and 1-a
  logic [61:0] sr_rem [32][2];
  logic [31:0] sr_root [32][2];
  always_ff @(posedge clk) begin
    sr_rem[0][0] <= {1'b0, a_cl, 30'd0};
    sr_rem[0][1] <= {1'b0, 31'h40000000 - a_cl, 30'd0};
    sr_root[0][0] <= '0;
    sr_root[0][1] <= '0;
  end
  for (genvar b = 0; b < 31; b++) begin : g_sqrt
    gcd_sqrt_cell #(.Bit(30 - b)) u_cell (
      .clk(clk), .rem_in(sr_rem[b]), .root_in(sr_root[b]),
      .rem_out(sr_rem[b+1]), .root_out(sr_root[b+1])
    );
  end

  // vectoring chain
  logic signed [W-1:0] vx [CORDIC_STEPS+1], vy [CORDIC_STEPS+1], vz [CORDIC_STEPS+1];
  assign vx[0] = W'(sr_root[31][1]);
  assign vy[0] = W'(sr_root[31][0]);
  assign vz[0] = '0;
  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_vec
    gcd_vec_cell #(.Step(s)) u_cell (
      .clk(clk), .x_in(vx[s]), .y_in(vy[s]), .z_in(vz[s]),
      .x_out(vx[s+1]), .y_out(vy[s+1]), .z_out(vz[s+1])
    );
  end

  // scaling: z*R, then *scale split into two halves
  logic [30:0] zc;
  always_comb begin
    if (vz[CORDIC_STEPS] < 0) zc = '0;
    else if (vz[CORDIC_STEPS] > gcd_pkg::OneQ30) zc = 31'h40000000;
    else zc = vz[CORDIC_STEPS][30:0];
  end
  logic [53:0] zr;
  logic [88:0] pl, ph;
  logic [88:0] prod;
  logic [63:0] dist_full;
  always_ff @(posedge clk) begin
    zr <= 54'(zc) * 54'(radius);
    pl <= 89'(zr[26:0]) * 89'(gcd_pkg::MmScale);
    ph <= (89'(zr[53:27]) * 89'(gcd_pkg::MmScale)) << 27;
    prod <= pl + ph + (89'd1 << 51);
    dist_full <= 64'(prod >> 52);
  end
  assign distance_mm = (dist_full > gcd_pkg::OutMax) ? 35'(gcd_pkg::OutMax)
                                                      : dist_full[34:0];

  `GCD_ASSERT_NEVER(a_busy_low, clk, rst, busy, "busy raised")
  `GCD_ASSERT_IMPL(a_done_follows, clk, rst, start |-> ##(Lat) done, "result lost")
  `GCD_ASSERT_NEVER(a_sat, clk, rst, done && (distance_mm > 35'(gcd_pkg::OutMax)), "over max")
endmodule
